[rtl/rmve_pkg.sv]
// Shared types and constants of the running mean and variance estimator.
// Depends on nothing; every other file refers to it by scoped names.
package rmve_pkg;

  localparam int DATA_W  = 32;  // sample, mean and variance width
  localparam int FRAC_W  = 16;  // fraction bits of the Q format
  localparam int COUNT_W = 32;  // sample counter width
  localparam int TOL_W   = 16;  // tolerance register width

  localparam int MAG_W   = DATA_W + 1;       // |sample - mean|
  localparam int PROD_W  = 2 * MAG_W;        // multiplier result
  localparam int DIVD_W  = 2 * DATA_W;       // divider dividend
  localparam int SQ_W    = 2 * DATA_W + 1 - FRAC_W;  // scaled square width
  localparam int LEN_W   = 7;                // divider step count width

  localparam logic [LEN_W-1:0] LEN_MEAN = LEN_W'(MAG_W);
  localparam logic [LEN_W-1:0] LEN_VAR  = LEN_W'(DIVD_W);
  localparam logic [LEN_W-1:0] LEN_SQ   = LEN_W'(SQ_W);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [DATA_W-1:0]  VAR_MAX   = '1;

  localparam logic [TOL_W-1:0] MEAN_TOL_RST = TOL_W'(655);
  localparam logic [TOL_W-1:0] VAR_TOL_RST  = TOL_W'(66);

  // configuration register indexes
  localparam logic CFG_MEAN_TOL = 1'b0;
  localparam logic CFG_VAR_TOL  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_V,
    ST_DIVV_GO,
    ST_DIVV_WAIT,
    ST_MUL_S,
    ST_DIVS_GO,
    ST_DIVS_WAIT,
    ST_DIVM_GO,
    ST_DIVM_WAIT,
    ST_FIN
  } state_t;

  // request to the serial divider; dividend is left aligned
  typedef struct packed {
    logic               start;
    logic [LEN_W-1:0]   len;
    logic [DIVD_W-1:0]  dividend;
    logic [DATA_W-1:0]  divisor;
  } div_req_t;

endpackage

[rtl/rmve_mul.sv]
// Registered multiplier shared by the two products of a variance update.
// Depends on rmve_pkg for operand widths.
module rmve_mul (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rmve_pkg::MAG_W-1:0]   a,
  input  logic [rmve_pkg::MAG_W-1:0]   b,
  output logic [rmve_pkg::PROD_W-1:0]  p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= rmve_pkg::PROD_W'(a) * rmve_pkg::PROD_W'(b);
    end
  end

endmodule

[rtl/rmve_div.sv]
// Restoring serial divider, one quotient bit per cycle, shared by all quotients.
// Depends on rmve_pkg for div_req_t and widths.
module rmve_div (
  input  logic                         clk,
  input  logic                         rst,
  input  rmve_pkg::div_req_t           req,
  output logic                         done,
  output logic [rmve_pkg::DIVD_W-1:0]  quotient
);

  logic [rmve_pkg::DATA_W-1:0] rem;
  logic [rmve_pkg::DATA_W-1:0] dvs;
  logic [rmve_pkg::LEN_W-1:0]  cnt;
  logic                        busy;
  logic [rmve_pkg::DATA_W:0]   rem_sh;
  logic                        ge;

  assign rem_sh = {rem, quotient[rmve_pkg::DIVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && busy && (cnt == rmve_pkg::LEN_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.len;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == rmve_pkg::LEN_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // dividend bits shift out the top while quotient bits fill in at the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= '0;
      dvs      <= req.divisor;
      quotient <= req.dividend;
    end else if (busy) begin
      rem      <= ge ? rmve_pkg::DATA_W'(rem_sh - {1'b0, dvs}) : rem_sh[rmve_pkg::DATA_W-1:0];
      quotient <= {quotient[rmve_pkg::DIVD_W-2:0], ge};
    end
  end

endmodule

[rtl/running_mean_variance_estimator.sv]
// Top level: sequencer and state of the running mean and variance estimator.
// Depends on rmve_pkg, rmve_mul and rmve_div.
//
//   channel   direction  signals
//   sample    in         sample_valid, sample_ready, sample
//   result    out        result_valid, result_ready, mean_estimate,
//                        variance_estimate, sample_count, converged
//   config    in         cfg_write, cfg_index, cfg_data
//
// The first sample after reset goes from accept and prepare to the result write.
// Every later sample runs three divisions (64, 49 and 33 quotient bits) one after
// another through the serial divider at one bit per cycle, each with a start and a
// finish state, plus accept, prepare, two multiplies and the result write.
// Reset returns mean, variance and count to zero and the tolerances to defaults.
// A finished result waits in the output register; a stalled result side holds
// the last step of the next sample until the register is free.
module running_mean_variance_estimator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic signed [31:0]            sample,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic signed [31:0]            mean_estimate,
  output logic [31:0]                   variance_estimate,
  output logic [31:0]                   sample_count,
  output logic                          converged,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [15:0]                   cfg_data
);

  rmve_pkg::state_t state, state_next;

  logic [rmve_pkg::TOL_W-1:0]   mean_tol;
  logic [rmve_pkg::TOL_W-1:0]   var_tol;
  logic [rmve_pkg::DATA_W-1:0]  mean_reg;
  logic [rmve_pkg::DATA_W-1:0]  variance_reg;
  logic [rmve_pkg::COUNT_W-1:0] count_reg;

  logic [rmve_pkg::DATA_W-1:0]  x;
  logic [rmve_pkg::COUNT_W-1:0] n;
  logic [rmve_pkg::MAG_W-1:0]   ad;
  logic                         neg;
  logic                         first;
  logic [rmve_pkg::DATA_W-1:0]  keep;
  logic [rmve_pkg::SQ_W-1:0]    sq_q;
  logic [rmve_pkg::MAG_W-1:0]   stepm;

  logic                         mul_en;
  logic [rmve_pkg::MAG_W-1:0]   mul_a;
  logic [rmve_pkg::MAG_W-1:0]   mul_b;
  logic [rmve_pkg::PROD_W-1:0]  prod;

  rmve_pkg::div_req_t           dreq;
  logic                         div_done;
  logic [rmve_pkg::DIVD_W-1:0]  quot;

  logic [rmve_pkg::MAG_W-1:0]   diff;
  logic [rmve_pkg::DATA_W:0]    vsum;
  logic                         vsat;
  logic [rmve_pkg::DATA_W-1:0]  new_v;
  logic [rmve_pkg::DATA_W-1:0]  new_m;
  logic [rmve_pkg::DATA_W-1:0]  dv;
  logic                         conv;
  logic                         out_free;

  rmve_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  rmve_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (dreq),
    .done     (div_done),
    .quotient (quot)
  );

  assign sample_ready = (state == rmve_pkg::ST_IDLE);
  assign out_free     = !result_valid || result_ready;

  assign diff = {x[rmve_pkg::DATA_W-1], x} - {mean_reg[rmve_pkg::DATA_W-1], mean_reg};

  // finishing arithmetic: saturating variance sum, mean step, convergence test
  assign vsum  = {1'b0, keep} + {1'b0, sq_q[rmve_pkg::DATA_W-1:0]};
  assign vsat  = (|sq_q[rmve_pkg::SQ_W-1:rmve_pkg::DATA_W]) || vsum[rmve_pkg::DATA_W];
  assign new_v = first ? '0 : (vsat ? rmve_pkg::VAR_MAX : vsum[rmve_pkg::DATA_W-1:0]);
  assign new_m = first ? x :
                 (neg ? mean_reg - stepm[rmve_pkg::DATA_W-1:0]
                      : mean_reg + stepm[rmve_pkg::DATA_W-1:0]);
  assign dv    = (new_v > variance_reg) ? new_v - variance_reg : variance_reg - new_v;
  assign conv  = !first && (stepm < rmve_pkg::MAG_W'(mean_tol))
                        && (dv < rmve_pkg::DATA_W'(var_tol));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmve_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    mul_en        = 1'b0;
    mul_a         = ad;
    mul_b         = ad;
    dreq.start    = 1'b0;
    dreq.len      = rmve_pkg::LEN_MEAN;
    dreq.dividend = {ad, (rmve_pkg::DIVD_W - rmve_pkg::MAG_W)'(0)};
    dreq.divisor  = n;
    case (state)
      rmve_pkg::ST_IDLE: begin
        if (sample_valid) state_next = rmve_pkg::ST_PREP;
      end
      rmve_pkg::ST_PREP: begin
        state_next = (count_reg == '0) ? rmve_pkg::ST_FIN : rmve_pkg::ST_MUL_V;
      end
      rmve_pkg::ST_MUL_V: begin
        mul_en     = 1'b1;
        mul_a      = rmve_pkg::MAG_W'(n - 2'd2);
        mul_b      = rmve_pkg::MAG_W'(variance_reg);
        state_next = rmve_pkg::ST_DIVV_GO;
      end
      rmve_pkg::ST_DIVV_GO: begin
        dreq.start    = 1'b1;
        dreq.len      = rmve_pkg::LEN_VAR;
        dreq.dividend = prod[rmve_pkg::DIVD_W-1:0];
        dreq.divisor  = n - 1'b1;
        state_next    = rmve_pkg::ST_DIVV_WAIT;
      end
      rmve_pkg::ST_DIVV_WAIT: begin
        if (div_done) state_next = rmve_pkg::ST_MUL_S;
      end
      rmve_pkg::ST_MUL_S: begin
        mul_en     = 1'b1;
        state_next = rmve_pkg::ST_DIVS_GO;
      end
      rmve_pkg::ST_DIVS_GO: begin
        dreq.start    = 1'b1;
        dreq.len      = rmve_pkg::LEN_SQ;
        dreq.dividend = {prod[rmve_pkg::PROD_W-2:rmve_pkg::FRAC_W],
                         (rmve_pkg::DIVD_W - rmve_pkg::SQ_W)'(0)};
        state_next    = rmve_pkg::ST_DIVS_WAIT;
      end
      rmve_pkg::ST_DIVS_WAIT: begin
        if (div_done) state_next = rmve_pkg::ST_DIVM_GO;
      end
      rmve_pkg::ST_DIVM_GO: begin
        dreq.start = 1'b1;
        state_next = rmve_pkg::ST_DIVM_WAIT;
      end
      rmve_pkg::ST_DIVM_WAIT: begin
        if (div_done) state_next = rmve_pkg::ST_FIN;
      end
      rmve_pkg::ST_FIN: begin
        if (out_free) state_next = rmve_pkg::ST_IDLE;
      end
      default: state_next = rmve_pkg::ST_IDLE;
    endcase
  end

  // working registers of one update
  always_ff @(posedge clk) begin
    case (state)
      rmve_pkg::ST_IDLE: begin
        if (sample_valid) x <= sample;
      end
      rmve_pkg::ST_PREP: begin
        first <= (count_reg == '0);
        n     <= (count_reg == '0) ? rmve_pkg::COUNT_W'(1) :
                 (count_reg == rmve_pkg::COUNT_MAX) ? rmve_pkg::COUNT_MAX :
                 count_reg + 1'b1;
        neg   <= diff[rmve_pkg::MAG_W-1];
        ad    <= diff[rmve_pkg::MAG_W-1] ? -diff : diff;
      end
      rmve_pkg::ST_DIVV_WAIT: begin
        if (div_done) keep <= quot[rmve_pkg::DATA_W-1:0];
      end
      rmve_pkg::ST_DIVS_WAIT: begin
        if (div_done) sq_q <= quot[rmve_pkg::SQ_W-1:0];
      end
      rmve_pkg::ST_DIVM_WAIT: begin
        if (div_done) stepm <= quot[rmve_pkg::MAG_W-1:0];
      end
      default: ;
    endcase
  end

  // estimator state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mean_reg     <= '0;
      variance_reg <= '0;
      count_reg    <= '0;
      result_valid <= 1'b0;
      mean_tol     <= rmve_pkg::MEAN_TOL_RST;
      var_tol      <= rmve_pkg::VAR_TOL_RST;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          rmve_pkg::CFG_MEAN_TOL: mean_tol <= cfg_data;
          rmve_pkg::CFG_VAR_TOL:  var_tol  <= cfg_data;
          default: ;
        endcase
      end
      if (state == rmve_pkg::ST_FIN && out_free) begin
        mean_reg     <= new_m;
        variance_reg <= new_v;
        count_reg    <= n;
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == rmve_pkg::ST_FIN && out_free) begin
      mean_estimate     <= new_m;
      variance_estimate <= new_v;
      sample_count      <= n;
      converged         <= conv;
    end
  end

endmodule

[test/running_mean_variance_estimator_tb.sv]
// Self-checking bench for the running mean and variance estimator.
// Holds a bit-exact predictor of the running update inside a small scoreboard class.
// Depends on rmve_pkg and the running_mean_variance_estimator RTL.

typedef struct packed {
  logic signed [31:0] mean;
  logic [31:0]        variance;
  logic [31:0]        count;
  logic               conv;
} stats_t;

class stats_scoreboard;
  logic signed [31:0] mean;
  logic [31:0]        variance;
  logic [31:0]        count;
  logic [15:0]        mean_tol;
  logic [15:0]        var_tol;
  stats_t             expected_stats[$];
  int unsigned        failures;

  function new();
    mean      = '0;
    variance  = '0;
    count     = '0;
    mean_tol  = rmve_pkg::MEAN_TOL_RST;
    var_tol   = rmve_pkg::VAR_TOL_RST;
    failures  = 0;
  endfunction

  function void set_tolerance(logic index, logic [15:0] value);
    if (index == rmve_pkg::CFG_MEAN_TOL) begin
      mean_tol = value;
    end else begin
      var_tol = value;
    end
  endfunction

  function int unsigned pending();
    return expected_stats.size();
  endfunction

  function void fail(string msg);
    failures++;
    $error("%s", msg);
  endfunction

  // Apply one accepted sample to the running estimate and queue the result.
  function void note_sample(logic [31:0] x);
    logic [33:0]  diff;
    logic [32:0]  mag;
    logic [31:0]  n;
    logic [31:0]  step;
    logic [127:0] keep;
    logic [127:0] sq;
    logic [127:0] total;
    logic [31:0]  new_var;
    logic [31:0]  dvar;
    stats_t       r;
    r.conv = 1'b0;
    if (count == '0) begin
      mean     = x;
      variance = '0;
      count    = 32'd1;
    end else begin
      n    = (count == rmve_pkg::COUNT_MAX) ? count : count + 32'd1;
      diff = {{2{x[31]}}, x} - {{2{mean[31]}}, mean};
      mag  = diff[33] ? 33'(-diff) : 33'(diff);
      step = 32'(mag / {1'b0, n});
      keep = ({96'b0, n - 32'd2} * {96'b0, variance}) / {96'b0, n - 32'd1};
      sq   = (({95'b0, mag} * {95'b0, mag}) >> rmve_pkg::FRAC_W) / {96'b0, n};
      total = keep + sq;
      // saturate the variance at full scale
      new_var = (total > {96'b0, rmve_pkg::VAR_MAX}) ? rmve_pkg::VAR_MAX : total[31:0];
      dvar = (new_var > variance) ? new_var - variance : variance - new_var;
      r.conv = (step < {16'b0, mean_tol}) && (dvar < {16'b0, var_tol});
      mean     = diff[33] ? mean - step : mean + step;
      variance = new_var;
      count    = n;
    end
    r.mean     = mean;
    r.variance = variance;
    r.count    = count;
    expected_stats.push_back(r);
  endfunction

  function void check_stats(logic signed [31:0] mean_v, logic [31:0] var_v,
                            logic [31:0] cnt_v, logic conv_v);
    stats_t e;
    if (expected_stats.size() == 0) begin
      fail("result with no sample request outstanding");
      return;
    end
    e = expected_stats.pop_front();
    if (mean_v !== e.mean) begin
      fail($sformatf("mean_estimate: expected %0d, got %0d", e.mean, mean_v));
    end
    if (var_v !== e.variance) begin
      fail($sformatf("variance_estimate: expected %0d, got %0d", e.variance, var_v));
    end
    if (cnt_v !== e.count) begin
      fail($sformatf("sample_count: expected %0d, got %0d", e.count, cnt_v));
    end
    if (conv_v !== e.conv) begin
      fail($sformatf("converged: expected %0d, got %0d", e.conv, conv_v));
    end
  endfunction
endclass

module running_mean_variance_estimator_tb;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned PHASE_ITEMS  = 160;
  localparam int unsigned NUM_PHASES   = 6;
  localparam int unsigned DRAIN_CYCLES = 200;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               sample_valid = 1'b0;
  logic               sample_ready;
  logic signed [31:0] sample = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic signed [31:0] mean_estimate;
  logic [31:0]        variance_estimate;
  logic [31:0]        sample_count;
  logic               converged;
  logic               cfg_write = 1'b0;
  logic               cfg_index = rmve_pkg::CFG_MEAN_TOL;
  logic [15:0]        cfg_data = '0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;

  stats_scoreboard sb;

  running_mean_variance_estimator dut (
    .clk               (clk),
    .rst               (rst),
    .sample_valid      (sample_valid),
    .sample_ready      (sample_ready),
    .sample            (sample),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .mean_estimate     (mean_estimate),
    .variance_estimate (variance_estimate),
    .sample_count      (sample_count),
    .converged         (converged),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("running_mean_variance_estimator regression: fail");
      $finish;
    end
  end

  // Result side: check on every accepted result, then pick next cycle's ready.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) begin
        sb.check_stats(mean_estimate, variance_estimate, sample_count, converged);
      end
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_sample(input logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= value;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    sb.note_sample(value);
  endtask

  // Drop valid and wait until every queued result has come back.
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_tolerances(input logic [15:0] mtol, input logic [15:0] vtol);
    cfg_write <= 1'b1;
    cfg_index <= rmve_pkg::CFG_MEAN_TOL;
    cfg_data  <= mtol;
    @(posedge clk);
    sb.set_tolerance(rmve_pkg::CFG_MEAN_TOL, mtol);
    cfg_index <= rmve_pkg::CFG_VAR_TOL;
    cfg_data  <= vtol;
    @(posedge clk);
    sb.set_tolerance(rmve_pkg::CFG_VAR_TOL, vtol);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idle_mode(input int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
      default: begin send_idle_pct = 28; recv_stall_pct = 28; end
    endcase
  endtask

  // Clustered samples around a drifting center, with some wider noise;
  // the first phase throws in full-range values in place of the wider noise.
  task automatic run_phase(input int unsigned idx, input int unsigned items);
    int          center;
    int          spread;
    int unsigned pick;
    logic [31:0] value;
    center = 0;
    spread = 16;
    for (int k = 0; k < items; k++) begin
      if (k % 40 == 0) begin
        center = int'($urandom_range(1 << 25)) - (1 << 24);
        spread = 1 << (4 + 4 * $urandom_range(4));
      end
      pick = $urandom_range(99);
      if (idx == 0 && pick < 10) begin
        value = $urandom;
      end else if (pick < 8) begin
        value = center + (int'($urandom_range(1 << 23)) - (1 << 22));
      end else begin
        value = center + (int'($urandom_range(2 * spread)) - spread);
      end
      send_sample(value);
    end
    drain_results();
  endtask

  initial begin
    logic [15:0] mtol;
    logic [15:0] vtol;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first sample after reset, zero deltas, tiny deltas
    set_idle_mode(0);
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0001);
    send_sample(32'hFFFF_FFFF);
    // mean step right at and just under the default tolerance
    send_sample(32'd3275);
    send_sample(32'd4579);
    // field extremes, variance saturation
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h0001_0000);
    send_sample(32'hFFFF_0000);
    drain_results();

    set_tolerances(16'hFFFF, 16'hFFFF);
    send_sample(32'h0000_8000);
    send_sample(32'h0000_8000);
    send_sample(32'hFFFF_8000);
    send_sample(32'h0000_0000);
    drain_results();

    // strict compare: nothing converges with zero tolerance
    set_tolerances(16'h0000, 16'h0000);
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0000);
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin mtol = rmve_pkg::MEAN_TOL_RST; vtol = rmve_pkg::VAR_TOL_RST; end
        2: begin mtol = 16'hFFFF; vtol = 16'h0000; end
        3: begin mtol = 16'h0000; vtol = 16'hFFFF; end
        5: begin mtol = 16'hFFFF; vtol = 16'hFFFF; end
        default: begin mtol = 16'($urandom); vtol = 16'($urandom); end
      endcase
      set_idle_mode(p);
      set_tolerances(mtol, vtol);
      run_phase(p, PHASE_ITEMS);
    end

    set_idle_mode(0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("running_mean_variance_estimator regression: pass");
    end else begin
      $display("running_mean_variance_estimator regression: fail");
    end
    $finish;
  end

endmodule
